### sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define VNA_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vna check failed");

// next-cycle implication, skipped while reset is high
`define VNA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vna check failed");

`endif

### sv/vna_pkg.sv
// types and constants for the vector norm accumulator
// no dependencies; used by every module of the block
package vna_pkg;

  localparam int ACC_WIDTH  = 64;
  localparam int OUT_WIDTH  = 48;
  localparam int ROOT_WIDTH = 32;
  localparam int ELEM_WIDTH = 32;

  localparam logic [1:0] MODE_SUM    = 2'd1;
  localparam logic [1:0] MODE_EUCLID = 2'd2;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] element;
    logic                         has_value;
    logic                         last;
  } vna_in_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] norm_value;
    logic                 saturated;
  } vna_out_t;

  typedef struct packed {
    logic start_root;
    logic load_out;
  } vna_cmd_t;

  typedef struct packed {
    logic pipe_last;
    logic fold_last;
    logic fin_euclid;
    logic root_done;
  } vna_stat_t;

endpackage

### sv/vna_root.sv
// iterative integer square root, one result bit per cycle
// depends on vna_pkg
module vna_root (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [vna_pkg::ACC_WIDTH-1:0]  radicand,
  output logic [vna_pkg::ROOT_WIDTH-1:0] root,
  output logic                           done
);
  import vna_pkg::*;

  localparam int REM_W = ROOT_WIDTH + 2;
  localparam int SH_W  = ROOT_WIDTH + 4;
  localparam int CNT_W = $clog2(ROOT_WIDTH);

  logic                 run;
  logic [CNT_W-1:0]     cnt;
  logic [ACC_WIDTH-1:0] rad;
  logic [REM_W-1:0]     rem;
  logic [SH_W-1:0]      rem_sh;
  logic [SH_W-1:0]      trial;
  logic [SH_W-1:0]      rem_dif;
  logic                 ge;

  // bring down the next two radicand bits and try a one in the root
  assign rem_sh  = {rem, rad[ACC_WIDTH-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_dif = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == '0)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(ROOT_WIDTH - 1);
    end else if (run) begin
      rad  <= {rad[ACC_WIDTH-3:0], 2'b00};
      rem  <= ge ? rem_dif[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_WIDTH-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

### sv/vna_dp.sv
// datapath: magnitude, square, accumulator, square root and result register
// depends on vna_pkg and vna_root
module vna_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  vna_pkg::vna_in_t   sample,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  input  vna_pkg::vna_cmd_t  cmd,
  output vna_pkg::vna_stat_t stat,
  output vna_pkg::vna_out_t  result
);
  import vna_pkg::*;

  localparam int SQ_W  = 2 * DATA_WIDTH;
  localparam int SUM_W = ACC_WIDTH + 1;

  logic [1:0]            mode;
  logic [DATA_WIDTH-1:0] el;
  logic [DATA_WIDTH-1:0] mag_in;

  logic                  s1_v;
  logic                  s1_hv;
  logic                  s1_last;
  logic [1:0]            s1_mode;
  logic [DATA_WIDTH-1:0] s1_mag;

  logic                  s2_v;
  logic                  s2_hv;
  logic                  s2_last;
  logic [1:0]            s2_mode;
  logic [DATA_WIDTH-1:0] s2_mag;
  logic [SQ_W-1:0]       s2_sq;

  logic [ACC_WIDTH-1:0]  acc;
  logic [ACC_WIDTH-1:0]  acc_next;
  logic                  ovf;
  logic                  ovf_next;
  logic [1:0]            fin_mode;
  logic [SUM_W-1:0]      sum_abs;
  logic [SUM_W-1:0]      sum_sq;
  logic [ACC_WIDTH-1:0]  mag_wide;
  logic [OUT_WIDTH-1:0]  clamped;
  logic [ROOT_WIDTH-1:0] root;
  logic                  root_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  // only the low DATA_WIDTH bits of the element count, as two's complement
  assign el     = sample.element[DATA_WIDTH-1:0];
  assign mag_in = el[DATA_WIDTH-1] ? (~el + 1'b1) : el;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag  <= mag_in;
    s1_hv   <= sample.has_value;
    s1_last <= sample.last;
    s1_mode <= mode;
    s2_mag  <= s1_mag;
    s2_sq   <= s1_mag * s1_mag;
    s2_hv   <= s1_hv;
    s2_last <= s1_last;
    s2_mode <= s1_mode;
  end

  assign mag_wide = {{(ACC_WIDTH-DATA_WIDTH){1'b0}}, s2_mag};
  assign sum_abs  = {1'b0, acc} + {1'b0, mag_wide};
  assign sum_sq   = {1'b0, acc} + {{(SUM_W-SQ_W){1'b0}}, s2_sq};

  always_comb begin
    acc_next = acc;
    ovf_next = ovf;
    if (s2_v && s2_hv) begin
      unique case (s2_mode)
        MODE_SUM: begin
          if (sum_abs[SUM_W-1:OUT_WIDTH] != '0) begin
            acc_next = {{(ACC_WIDTH-OUT_WIDTH){1'b0}}, {OUT_WIDTH{1'b1}}};
            ovf_next = 1'b1;
          end else begin
            acc_next = sum_abs[ACC_WIDTH-1:0];
          end
        end
        MODE_EUCLID: begin
          if (sum_sq[SUM_W-1]) begin
            acc_next = '1;
            ovf_next = 1'b1;
          end else begin
            acc_next = sum_sq[ACC_WIDTH-1:0];
          end
        end
        default: begin
          if (mag_wide > acc) begin
            acc_next = mag_wide;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      ovf <= 1'b0;
    end else if (cmd.load_out) begin
      acc <= '0;
      ovf <= 1'b0;
    end else begin
      acc <= acc_next;
      ovf <= ovf_next;
    end
  end

  // the result takes the mode seen with the last item
  always_ff @(posedge clk) begin
    if (s2_v && s2_last) begin
      fin_mode <= s2_mode;
    end
  end

  vna_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_root),
    .radicand (acc),
    .root     (root),
    .done     (root_done)
  );

  assign clamped = (acc[ACC_WIDTH-1:OUT_WIDTH] != '0) ? '1 : acc[OUT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.norm_value <= (fin_mode == MODE_EUCLID) ?
                           {{(OUT_WIDTH-ROOT_WIDTH){1'b0}}, root} : clamped;
      result.saturated  <= ovf;
    end
  end

  assign stat.pipe_last  = (s1_v && s1_last) || (s2_v && s2_last);
  assign stat.fold_last  = s2_v && s2_last;
  assign stat.fin_euclid = (fin_mode == MODE_EUCLID);
  assign stat.root_done  = root_done;

endmodule

### sv/vna_ctrl.sv
// controller: input flow, end-of-vector sequencing and result valid
// depends on vna_pkg
module vna_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  vna_pkg::vna_stat_t stat,
  input  logic               result_stall,
  output vna_pkg::vna_cmd_t  cmd,
  output logic               sample_stall,
  output logic               result_valid
);
  import vna_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_FIN,
    S_ROOT,
    S_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd.start_root = (state == S_FIN) && stat.fin_euclid;
    cmd.load_out   = (state == S_EMIT) && (!result_valid || !result_stall);
    // hold the input once a last item is in flight until its result is out
    sample_stall   = (state != S_RUN) || stat.pipe_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (stat.fold_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= stat.fin_euclid ? S_ROOT : S_EMIT;
        end
        S_ROOT: begin
          if (stat.root_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (cmd.load_out) begin
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

endmodule

### sv/vector_norm_accumulator.sv
// vector norm accumulator: max, sum of absolutes or euclidean norm
// the last item goes through s1, s2, the accumulator, S_FIN, S_ROOT (euclidean), S_EMIT
// to result valid; throughput: one item per cycle within a vector; after the last item
// the input stalls until the result is loaded (bit-serial square root in euclidean mode)
// reset (rst, synchronous): mode 0, accumulator and overflow cleared, no result pending
// depends on vna_pkg, vna_ctrl, vna_dp
module vector_norm_accumulator #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  vna_pkg::vna_in_t  sample,
  output logic              result_valid,
  input  logic              result_stall,
  output vna_pkg::vna_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);
  import vna_pkg::*;

  vna_cmd_t  cmd;
  vna_stat_t stat;
  logic      accept;

  assign accept    = sample_valid && !sample_stall;
  assign cfg_ready = 1'b1;

  vna_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .stat         (stat),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sample_stall (sample_stall),
    .result_valid (result_valid)
  );

  vna_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (sample),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

### sv/vna_checker.sv
// port-level checks for the vector norm accumulator, bound to the top level
// depends on vna_pkg and assert_macros.svh
`include "assert_macros.svh"

module vna_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input vna_pkg::vna_in_t  sample,
  input logic              result_valid,
  input logic              result_stall,
  input vna_pkg::vna_out_t result
);
  import vna_pkg::*;

  // a stalled result holds
  `VNA_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

  // a last item closes the input; the check covers the stall right after it is taken
  `VNA_ASSERT_NEXT(a_last_stalls, clk, rst, sample_valid && !sample_stall && sample.last, sample_stall)

  // a clamped result is never zero
  `VNA_ASSERT_NOW(a_sat_nonzero, clk, rst, result_valid && result.saturated, result.norm_value != '0)

endmodule

bind vector_norm_accumulator vna_checker u_vna_checker (.*);
